[hw/rtl/wrns_pkg.sv]
// Shared constants, types and the weight function of the weighted random node selector.
package wrns_pkg;

  localparam int unsigned MaxNodes = 16;
  localparam int unsigned IdxW     = (MaxNodes > 1) ? $clog2(MaxNodes) : 1;
  localparam int unsigned CntW     = $clog2(MaxNodes + 1);
  localparam int unsigned IdW      = 32;
  localparam int unsigned LoadW    = 16;
  localparam int unsigned RndW     = 31;
  localparam int unsigned WgtW     = LoadW + 1;
  // The total weight is at most MaxNodes * 2^LoadW.
  localparam int unsigned TotW     = $clog2(MaxNodes * (2 ** LoadW) + 1);
  localparam int unsigned StepW    = $clog2(RndW);

  typedef enum logic [1:0] {
    ModeAdd = 2'd0,
    ModeDel = 2'd1,
    ModeSel = 2'd2,
    ModeNop = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    StatusOk   = 2'd0,
    StatusNone = 2'd1,
    StatusFull = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    StIdle,
    StFind,
    StShiftUp,
    StShiftDn,
    StSum,
    StDiv,
    StSearch
  } state_e;

  // Weight of a node: max_load - load + 1 when the load is selectable, else zero.
  function automatic logic [WgtW-1:0] node_weight(input logic [LoadW-1:0] load,
                                                  input logic [LoadW-1:0] max_load);
    logic [WgtW-1:0] w;
    if (load > max_load) begin
      w = '0;
    end else begin
      w = {1'b0, max_load} - {1'b0, load} + WgtW'(1);
    end
    return w;
  endfunction

endpackage

[hw/rtl/weighted_random_node_selector.sv]
// Top level of the weighted random node selector: node table, sequencer and result register.
//
// The block holds up to sixteen nodes (id and load) in ascending id order and takes one
// command item at a time: start is sampled while busy is low, and busy stays high until the
// item is finished. Each item produces exactly one result, shown on status_o, chosen_id_o and
// chosen_load_o for a single cycle with done_o high; the receiver cannot stall, so it must
// capture the result in that cycle. A new item may be started in the very cycle done_o is high.
// Timing follows from one table read per cycle through a single sequencer. Add and delete scan
// the table from the front until the id is found or passed and then, for a new add or a found
// delete, shift the entries behind that point one per cycle. An add shifts from the end of the
// table back to where the scan stopped; a delete shifts from the found entry toward the end.
// A select sums the weights one entry per cycle, reduces the random value in a bit-serial
// modulo unit, and walks the ranges again one entry per cycle. The result appears in the same
// cycle that busy falls. An empty selection finishes after the sum. The ignored mode three
// finishes in the accept cycle.
// max_load may be written at any edge while the block is idle; it resets to 100.
module weighted_random_node_selector (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 mode_i,
  input  logic [wrns_pkg::IdW-1:0]   node_id_i,
  input  logic [wrns_pkg::LoadW-1:0] node_load_i,
  input  logic [wrns_pkg::RndW-1:0]  random_value_i,
  input  logic                       cfg_we_i,
  input  logic [wrns_pkg::LoadW-1:0] cfg_wdata_i,
  output logic                       done_o,
  output logic [1:0]                 status_o,
  output logic [wrns_pkg::IdW-1:0]   chosen_id_o,
  output logic [wrns_pkg::LoadW-1:0] chosen_load_o
);

  // Node table. Only the first count_q entries hold stored nodes.
  logic [wrns_pkg::IdW-1:0]   entry_id_q   [wrns_pkg::MaxNodes];
  logic [wrns_pkg::LoadW-1:0] entry_load_q [wrns_pkg::MaxNodes];

  wrns_pkg::state_e           state_q, state_d;
  wrns_pkg::mode_e            mode_q, mode_d;
  logic [wrns_pkg::IdW-1:0]   id_q, id_d;
  logic [wrns_pkg::LoadW-1:0] load_q, load_d;
  logic [wrns_pkg::RndW-1:0]  rnd_q, rnd_d;
  logic [wrns_pkg::LoadW-1:0] max_load_q;
  logic [wrns_pkg::CntW-1:0]  count_q, count_d;
  logic [wrns_pkg::CntW-1:0]  idx_q, idx_d;
  logic [wrns_pkg::CntW-1:0]  pos_q, pos_d;
  logic [wrns_pkg::TotW-1:0]  acc_q, acc_d;
  logic [wrns_pkg::TotW-1:0]  seed_q, seed_d;

  // Result register.
  logic                       done_q, done_d;
  wrns_pkg::status_e          status_q, status_d;
  logic [wrns_pkg::IdW-1:0]   cid_q, cid_d;
  logic [wrns_pkg::LoadW-1:0] cload_q, cload_d;

  // Table read and write port.
  logic [wrns_pkg::CntW-1:0]  rd_ptr;
  logic [wrns_pkg::IdxW-1:0]  rd_idx;
  logic [wrns_pkg::IdW-1:0]   rd_id;
  logic [wrns_pkg::LoadW-1:0] rd_load;
  logic [wrns_pkg::WgtW-1:0]  rd_wgt;
  logic                       wr_en;
  logic [wrns_pkg::IdxW-1:0]  wr_idx;
  logic [wrns_pkg::IdW-1:0]   wr_id;
  logic [wrns_pkg::LoadW-1:0] wr_load;

  logic                       at_end;
  logic                       table_full;
  logic                       find_hit;
  logic                       find_miss;
  logic                       in_range;
  logic                       div_start;
  logic                       div_done;
  logic [wrns_pkg::TotW-1:0]  div_rem;

  assign busy = (state_q != wrns_pkg::StIdle);

  // Shifts read the neighbor of the entry being written; everything else reads at the index.
  always_comb begin
    unique case (state_q)
      wrns_pkg::StShiftUp: rd_ptr = idx_q - wrns_pkg::CntW'(1);
      wrns_pkg::StShiftDn: rd_ptr = idx_q + wrns_pkg::CntW'(1);
      default:             rd_ptr = idx_q;
    endcase
  end

  assign rd_idx     = rd_ptr[wrns_pkg::IdxW-1:0];
  assign rd_id      = entry_id_q[rd_idx];
  assign rd_load    = entry_load_q[rd_idx];
  assign rd_wgt     = wrns_pkg::node_weight(rd_load, max_load_q);

  assign at_end     = (idx_q == count_q);
  assign table_full = (count_q == wrns_pkg::CntW'(wrns_pkg::MaxNodes));
  assign find_hit   = !at_end && (rd_id == id_q);
  assign find_miss  = at_end || (!find_hit && (rd_id > id_q));
  assign in_range   = (rd_wgt != '0) &&
                      ({1'b0, seed_q} < ({1'b0, acc_q} + (wrns_pkg::TotW + 1)'(rd_wgt)));

  wrns_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rnd_q),
    .divisor_i  (acc_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wrns_pkg::StIdle: begin
        if (start) begin
          unique case (wrns_pkg::mode_e'(mode_i))
            wrns_pkg::ModeAdd,
            wrns_pkg::ModeDel: state_d = wrns_pkg::StFind;
            wrns_pkg::ModeSel: state_d = wrns_pkg::StSum;
            default:           state_d = wrns_pkg::StIdle;
          endcase
        end
      end
      wrns_pkg::StFind: begin
        if (find_hit) begin
          state_d = (mode_q == wrns_pkg::ModeDel) ? wrns_pkg::StShiftDn : wrns_pkg::StIdle;
        end else if (find_miss) begin
          if (mode_q == wrns_pkg::ModeAdd && !table_full) begin
            state_d = wrns_pkg::StShiftUp;
          end else begin
            state_d = wrns_pkg::StIdle;
          end
        end
      end
      wrns_pkg::StShiftUp: begin
        if (idx_q <= pos_q) begin
          state_d = wrns_pkg::StIdle;
        end
      end
      wrns_pkg::StShiftDn: begin
        if ((idx_q + wrns_pkg::CntW'(1)) >= count_q) begin
          state_d = wrns_pkg::StIdle;
        end
      end
      wrns_pkg::StSum: begin
        if (at_end) begin
          state_d = (acc_q == '0) ? wrns_pkg::StIdle : wrns_pkg::StDiv;
        end
      end
      wrns_pkg::StDiv: begin
        if (div_done) begin
          state_d = wrns_pkg::StSearch;
        end
      end
      wrns_pkg::StSearch: begin
        if (at_end || in_range) begin
          state_d = wrns_pkg::StIdle;
        end
      end
      default: state_d = wrns_pkg::StIdle;
    endcase
  end

  // Datapath, table writes and result.
  always_comb begin
    mode_d    = mode_q;
    id_d      = id_q;
    load_d    = load_q;
    rnd_d     = rnd_q;
    count_d   = count_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    acc_d     = acc_q;
    seed_d    = seed_q;
    done_d    = 1'b0;
    status_d  = status_q;
    cid_d     = cid_q;
    cload_d   = cload_q;
    wr_en     = 1'b0;
    wr_idx    = idx_q[wrns_pkg::IdxW-1:0];
    wr_id     = rd_id;
    wr_load   = rd_load;
    div_start = 1'b0;
    unique case (state_q)
      wrns_pkg::StIdle: begin
        if (start) begin
          mode_d = wrns_pkg::mode_e'(mode_i);
          id_d   = node_id_i;
          load_d = node_load_i;
          rnd_d  = random_value_i;
          idx_d  = '0;
          acc_d  = '0;
          if (wrns_pkg::mode_e'(mode_i) == wrns_pkg::ModeNop) begin
            done_d   = 1'b1;
            status_d = wrns_pkg::StatusOk;
            cid_d    = '0;
            cload_d  = '0;
          end
        end
      end
      wrns_pkg::StFind: begin
        if (find_hit) begin
          if (mode_q == wrns_pkg::ModeAdd) begin
            // Existing node: only the load changes, even with a full table.
            wr_en    = 1'b1;
            wr_id    = id_q;
            wr_load  = load_q;
            done_d   = 1'b1;
            status_d = wrns_pkg::StatusOk;
            cid_d    = '0;
            cload_d  = '0;
          end
        end else if (find_miss) begin
          if (mode_q == wrns_pkg::ModeAdd && !table_full) begin
            pos_d = idx_q;
            idx_d = count_q;
          end else begin
            done_d   = 1'b1;
            status_d = (mode_q == wrns_pkg::ModeAdd) ? wrns_pkg::StatusFull
                                                     : wrns_pkg::StatusOk;
            cid_d    = '0;
            cload_d  = '0;
          end
        end else begin
          idx_d = idx_q + wrns_pkg::CntW'(1);
        end
      end
      wrns_pkg::StShiftUp: begin
        wr_en = 1'b1;
        if (idx_q > pos_q) begin
          idx_d = idx_q - wrns_pkg::CntW'(1);
        end else begin
          wr_id    = id_q;
          wr_load  = load_q;
          count_d  = count_q + wrns_pkg::CntW'(1);
          done_d   = 1'b1;
          status_d = wrns_pkg::StatusOk;
          cid_d    = '0;
          cload_d  = '0;
        end
      end
      wrns_pkg::StShiftDn: begin
        if ((idx_q + wrns_pkg::CntW'(1)) < count_q) begin
          wr_en = 1'b1;
          idx_d = idx_q + wrns_pkg::CntW'(1);
        end else begin
          count_d  = count_q - wrns_pkg::CntW'(1);
          done_d   = 1'b1;
          status_d = wrns_pkg::StatusOk;
          cid_d    = '0;
          cload_d  = '0;
        end
      end
      wrns_pkg::StSum: begin
        if (at_end) begin
          idx_d = '0;
          acc_d = '0;
          if (acc_q == '0) begin
            done_d   = 1'b1;
            status_d = wrns_pkg::StatusNone;
            cid_d    = '0;
            cload_d  = '0;
          end else begin
            // The modulo unit latches the total on this edge.
            div_start = 1'b1;
          end
        end else begin
          acc_d = acc_q + wrns_pkg::TotW'(rd_wgt);
          idx_d = idx_q + wrns_pkg::CntW'(1);
        end
      end
      wrns_pkg::StDiv: begin
        if (div_done) begin
          seed_d = div_rem;
        end
      end
      wrns_pkg::StSearch: begin
        if (at_end) begin
          done_d   = 1'b1;
          status_d = wrns_pkg::StatusNone;
          cid_d    = '0;
          cload_d  = '0;
        end else if (in_range) begin
          done_d   = 1'b1;
          status_d = wrns_pkg::StatusOk;
          cid_d    = rd_id;
          cload_d  = rd_load;
        end else begin
          acc_d = acc_q + wrns_pkg::TotW'(rd_wgt);
          idx_d = idx_q + wrns_pkg::CntW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= wrns_pkg::StIdle;
      count_q    <= '0;
      max_load_q <= wrns_pkg::LoadW'(100);
      done_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        max_load_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    id_q     <= id_d;
    load_q   <= load_d;
    rnd_q    <= rnd_d;
    idx_q    <= idx_d;
    pos_q    <= pos_d;
    acc_q    <= acc_d;
    seed_q   <= seed_d;
    status_q <= status_d;
    cid_q    <= cid_d;
    cload_q  <= cload_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_id_q[wr_idx]   <= wr_id;
      entry_load_q[wr_idx] <= wr_load;
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign chosen_id_o   = cid_q;
  assign chosen_load_o = cload_q;

  // A result is always shown with the sequencer back at rest.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result strobe while the sequencer is busy");

  // The node count never passes the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   count_q <= wrns_pkg::CntW'(wrns_pkg::MaxNodes))
    else $error("node count beyond table depth");

  // An accepted select or table command keeps the block busy on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (start && !busy && (wrns_pkg::mode_e'(mode_i) != wrns_pkg::ModeNop))
                   |=> busy)
    else $error("accepted item did not occupy the sequencer");

  // An empty selection never reports a node.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (done_o && status_o == wrns_pkg::StatusNone) |->
                   (chosen_id_o == '0 && chosen_load_o == '0))
    else $error("empty selection reported a node");

endmodule

[hw/rtl/wrns_mod_unit.sv]
// Bit-serial restoring modulo unit: one remainder bit per cycle.
module wrns_mod_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [wrns_pkg::RndW-1:0] dividend_i,
  input  logic [wrns_pkg::TotW-1:0] divisor_i,
  output logic                      done_o,
  output logic [wrns_pkg::TotW-1:0] rem_o
);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [wrns_pkg::StepW-1:0] step_q, step_d;
  logic [wrns_pkg::RndW-1:0]  num_q, num_d;
  logic [wrns_pkg::TotW-1:0]  div_q, div_d;
  logic [wrns_pkg::TotW-1:0]  rem_q, rem_d;
  logic [wrns_pkg::TotW:0]    trial;

  // The remainder stays below the divisor, so the shifted trial fits one extra bit.
  assign trial = {rem_q, num_q[wrns_pkg::RndW-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    num_d  = num_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      num_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      num_d = {num_q[wrns_pkg::RndW-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_d = wrns_pkg::TotW'(trial - {1'b0, div_q});
      end else begin
        rem_d = trial[wrns_pkg::TotW-1:0];
      end
      if (step_q == wrns_pkg::StepW'(wrns_pkg::RndW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q + wrns_pkg::StepW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

[sim/tb_weighted_random_node_selector.sv]
// Self-checking testbench for the weighted random node selector: predictor, stimulus and checks.
module tb_weighted_random_node_selector;
  timeunit 1ns;
  timeprecision 1ps;

  import wrns_pkg::*;

  // Cycles without any accepted item or result before the run is declared hung. The slowest
  // item (a select on a full table) plus the longest sender gap stays far below this limit, so
  // it leaves a wide margin.
  localparam int unsigned WatchdogLimit = 1000;
  // Cycles to wait after the last result before the verdict, a bit over one slow select.
  localparam int unsigned TailCycles    = 80;
  localparam int unsigned ItemsPerPhase = 200;
  localparam int unsigned NumPhases     = 8;
  localparam int unsigned PoolSize      = 24;

  // One predicted result item.
  typedef struct {
    status_e          status;
    logic [IdW-1:0]   id;
    logic [LoadW-1:0] load;
  } pick_t;

  // Scoreboard: keeps its own copy of the node table and max_load, predicts the result of
  // every accepted item and checks the results in order.
  class selection_board;
    logic [IdW-1:0]   ids   [MaxNodes];
    logic [LoadW-1:0] loads [MaxNodes];
    int unsigned      count;
    logic [LoadW-1:0] max_load;
    pick_t            owed[$];
    int unsigned      errors, n_add, n_del, n_sel, n_none, n_full, n_nop;

    function new();
      count    = 0;
      max_load = 16'd100;
    endfunction

    function int unsigned weight_of(logic [LoadW-1:0] load);
      if (load > max_load) begin
        return 0;
      end
      return {16'd0, max_load} - {16'd0, load} + 32'd1;
    endfunction

    // Position of the id if stored, else the position where it would be inserted.
    function int unsigned locate(input logic [IdW-1:0] id, output bit hit);
      int unsigned i;
      i = 0;
      while (i < count && ids[i] < id) i++;
      hit = (i < count) && (ids[i] == id);
      return i;
    endfunction

    function void note_item(mode_e mode, logic [IdW-1:0] id, logic [LoadW-1:0] load,
                            logic [RndW-1:0] rnd);
      pick_t       res;
      bit          hit, found;
      int unsigned pos, total, seed, base, w;
      res.status = StatusOk;
      res.id     = '0;
      res.load   = '0;
      case (mode)
        ModeAdd: begin
          n_add++;
          pos = locate(id, hit);
          if (hit) begin
            loads[pos] = load;
          end else if (count >= MaxNodes) begin
            res.status = StatusFull;
            n_full++;
          end else begin
            for (int i = count; i > pos; i--) begin
              ids[i]   = ids[i-1];
              loads[i] = loads[i-1];
            end
            ids[pos]   = id;
            loads[pos] = load;
            count++;
          end
        end
        ModeDel: begin
          n_del++;
          pos = locate(id, hit);
          if (hit) begin
            for (int i = pos; i + 1 < count; i++) begin
              ids[i]   = ids[i+1];
              loads[i] = loads[i+1];
            end
            count--;
          end
        end
        ModeSel: begin
          n_sel++;
          total = 0;
          for (int i = 0; i < count; i++) total += weight_of(loads[i]);
          if (total == 0) begin
            res.status = StatusNone;
            n_none++;
          end else begin
            // The weights form consecutive ranges in id order; find the one holding seed.
            seed  = {1'b0, rnd} % total;
            base  = 0;
            found = 0;
            for (int i = 0; i < count; i++) begin
              w = weight_of(loads[i]);
              if (!found && w != 0 && seed < base + w) begin
                res.id   = ids[i];
                res.load = loads[i];
                found    = 1;
              end
              base += w;
            end
          end
        end
        default: begin
          n_nop++;
        end
      endcase
      owed = {owed, res};
    endfunction

    function void check_result(logic [1:0] status, logic [IdW-1:0] id, logic [LoadW-1:0] load);
      pick_t want;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: result with no item outstanding: status %0d id %h load %h",
                   $realtime, status, id, load);
        end
        return;
      end
      want = owed.pop_front();
      if (status !== want.status || id !== want.id || load !== want.load) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: mismatch: status exp %0d got %0d, id exp %h got %h, load exp %h got %h",
                   $realtime, want.status, status, want.id, id, want.load, load);
        end
      end
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [1:0]           mode_i;
  logic [IdW-1:0]       node_id_i;
  logic [LoadW-1:0]     node_load_i;
  logic [RndW-1:0]      random_value_i;
  logic                 cfg_we_i;
  logic [LoadW-1:0]     cfg_wdata_i;
  logic                 done_o;
  logic [1:0]           status_o;
  logic [IdW-1:0]       chosen_id_o;
  logic [LoadW-1:0]     chosen_load_o;

  selection_board board = new();
  int unsigned    quiet_cycles;
  int unsigned    n_settings;
  logic [IdW-1:0] id_pool [PoolSize];

  weighted_random_node_selector i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .node_id_i      (node_id_i),
    .node_load_i    (node_load_i),
    .random_value_i (random_value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .chosen_id_o    (chosen_id_o),
    .chosen_load_o  (chosen_load_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Monitor: at every rising edge note an accepted item first and then check a result, so a
  // result that shows up in the very cycle of an accept is still matched in order. It also
  // runs the watchdog, which only counts cycles in which no item is accepted and no result shows.
  always @(posedge clk_i) begin : monitor
    bit moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (start && !busy) begin
        board.note_item(mode_e'(mode_i), node_id_i, node_load_i, random_value_i);
        moved = 1'b1;
      end
      if (done_o) begin
        board.check_result(status_o, chosen_id_o, chosen_load_o);
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: no progress for %0d cycles", $realtime, WatchdogLimit);
        $display("[weighted_random_node_selector] ERROR");
        $finish;
      end
    end
  end

  // Present one item at the falling edge and hold it until the block takes it. Start stays
  // high afterwards so that a following item can go back to back; hold_off lowers it.
  task automatic send_item(mode_e mode, logic [IdW-1:0] id, logic [LoadW-1:0] load,
                           logic [RndW-1:0] rnd);
    @(negedge clk_i);
    start          = 1'b1;
    mode_i         = mode;
    node_id_i      = id;
    node_load_i    = load;
    random_value_i = rnd;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic hold_off(int unsigned cycles);
    @(negedge clk_i);
    start = 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // max_load is only written while the block is idle, so drain every outstanding result
  // first and give the block a few cycles to settle.
  task automatic write_max_load(logic [LoadW-1:0] value);
    @(negedge clk_i);
    start = 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i       = 1'b1;
    cfg_wdata_i    = value;
    board.max_load = value;
    n_settings++;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Ids mostly come from a small pool so that updates, deletes of stored nodes and a full
  // table are common; now and then a fully random id goes in.
  function automatic logic [IdW-1:0] pick_id();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom;
    end
    return id_pool[$urandom_range(0, PoolSize - 1)];
  endfunction

  // Loads mostly lie within the selectable limit; some sit at or just beyond it or are fully random.
  function automatic logic [LoadW-1:0] pick_load();
    logic [LoadW-1:0] lim;
    lim = board.max_load;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return lim;
      2:       return (lim == 16'hFFFF) ? lim : lim + 16'd1;
      3:       return 16'hFFFF;
      4, 5:    return LoadW'($urandom);
      default: return LoadW'($urandom_range(0, lim));
    endcase
  endfunction

  function automatic logic [RndW-1:0] pick_rnd();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return {RndW{1'b1}};
      2:       return RndW'($urandom_range(0, 300));
      default: return RndW'($urandom >> 1);
    endcase
  endfunction

  // One random item. Add-heavy phases fill the table toward full, delete-heavy phases drain
  // it again; deletes often name a stored node so that they actually remove something.
  task automatic random_item(bit add_heavy, bit idling);
    int unsigned      roll;
    mode_e            mode;
    logic [IdW-1:0]   id;
    logic [LoadW-1:0] load;
    logic [RndW-1:0]  rnd;
    roll = $urandom_range(0, 99);
    id   = pick_id();
    load = pick_load();
    rnd  = pick_rnd();
    if (roll < (add_heavy ? 45 : 25)) begin
      mode = ModeAdd;
    end else if (roll < 60) begin
      mode = ModeDel;
      if (board.count != 0 && $urandom_range(0, 1) == 1) begin
        id = board.ids[$urandom_range(0, board.count - 1)];
      end
    end else if (roll < 95) begin
      mode = ModeSel;
    end else begin
      mode = ModeNop;
    end
    send_item(mode, id, load, rnd);
    if (idling && $urandom_range(0, 3) == 0) begin
      hold_off($urandom_range(1, 6));
    end
  endtask

  initial begin
    logic [LoadW-1:0] limit;
    rst_ni         = 1'b0;
    start          = 1'b0;
    mode_i         = '0;
    node_id_i      = '0;
    node_load_i    = '0;
    random_value_i = '0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    quiet_cycles   = 0;
    n_settings     = 0;
    id_pool[0] = '0;
    id_pool[1] = '1;
    id_pool[2] = 32'd1;
    id_pool[3] = 32'hFFFF_FFFE;
    for (int i = 4; i < PoolSize; i++) id_pool[i] = $urandom;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at the reset value of max_load: empty table, absent delete, the ignored
    // mode, the extreme ids, loads on both sides of the limit, and a table with no
    // selectable node left.
    write_max_load(16'd100);
    send_item(ModeSel, '0, '0, 31'd5);
    send_item(ModeDel, 32'd5, '0, '0);
    send_item(ModeNop, '1, '1, '1);
    send_item(ModeAdd, 32'hFFFF_FFFF, 16'hFFFF, '0);
    send_item(ModeAdd, 32'd7, 16'd100, '0);
    send_item(ModeAdd, 32'd0, 16'd0, '0);
    send_item(ModeAdd, 32'd3, 16'd101, '0);
    send_item(ModeSel, '0, '0, 31'd0);
    send_item(ModeSel, '0, '0, 31'd100);
    send_item(ModeSel, '0, '0, 31'd101);
    send_item(ModeSel, '1, '1, {RndW{1'b1}});
    send_item(ModeAdd, 32'd0, 16'hFFFF, '0);
    send_item(ModeSel, '0, '0, 31'd12345);
    send_item(ModeAdd, 32'd7, 16'd101, '0);
    send_item(ModeSel, '0, '0, 31'd9);
    send_item(ModeDel, 32'd3, '0, '0);
    send_item(ModeDel, 32'd7, '0, '0);
    send_item(ModeDel, 32'd0, '0, '0);
    send_item(ModeDel, 32'hFFFF_FFFF, '0, '0);
    send_item(ModeSel, '0, '0, 31'd1);

    // Random part: each phase runs under its own max_load, the extremes among them. The
    // last phase keeps the sender busy without gaps.
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0:       limit = 16'hFFFF;
        1:       limit = 16'd0;
        2:       limit = 16'd3;
        3:       limit = LoadW'($urandom);
        4:       limit = 16'd1;
        5:       limit = 16'hFFFE;
        6:       limit = LoadW'($urandom_range(2, 1000));
        default: limit = 16'd100;
      endcase
      write_max_load(limit);
      repeat (ItemsPerPhase) random_item(p % 2 == 0, p != NumPhases - 1);
    end

    @(negedge clk_i);
    start = 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("Covered %0d adds, %0d deletes, %0d selects and %0d ignored items",
             board.n_add, board.n_del, board.n_sel, board.n_nop);
    $display("under %0d max_load values; %0d full-table rejections, %0d empty selections.",
             n_settings, board.n_full, board.n_none);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("[weighted_random_node_selector] OK");
    end else begin
      $display("%0d mismatches.", board.errors);
      $display("[weighted_random_node_selector] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/wrns_pkg.sv
hw/rtl/wrns_mod_unit.sv
hw/rtl/weighted_random_node_selector.sv
sim/tb_weighted_random_node_selector.sv
